@@ rtl/core/ota_pkg.sv @@
`default_nettype none
package ota_pkg;

  localparam int DEPTH_DEF = 256;
  // widest entry index over the supported depth range (up to 4096 entries)
  localparam int IDX_W = 12;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_UPDATE    = 3'd6,
    OP_SEARCH    = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_INS  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_UPD  = 2'd3
  } cmd_kind_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cmd_kind_e                 kind;
    logic [IDX_W-1:0]          pos;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/ordered_array_table_engine.sv @@
`default_nettype none
// inserts, deletes and updates raise done in the cycle after they are accepted;
// a search holds busy high, taking no new beat, until the first-match tree gives its result
// throughput: one beat per cycle for all operations but search, set by the cell
// chain shifting all entries at once; a search is bound by the first-match tree
// done is a single-cycle strobe, the receiver cannot stall it
// synchronous reset empties the table and clears the fill count; entry contents are not cleared
module ordered_array_table_engine #(
  parameter int DEPTH = ota_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         operation,
  input  logic signed [ota_pkg::DATA_W-1:0]  value,
  input  logic [7:0]                         position,
  output logic                               done,
  output logic [2:0]                         status,
  output logic [7:0]                         found_index,
  output logic [8:0]                         fill_count
);
  import ota_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int L  = $clog2(DEPTH);
  localparam int PW = (CW > 8) ? CW : 8;
  localparam int SW = $clog2(L + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e         state, state_next;
  logic [CW-1:0]  count, count_next;
  logic [SW-1:0]  step;

  // chain of entry cells
  cmd_t                     cmd;
  logic signed [DATA_W-1:0] ent [DEPTH];
  logic [DEPTH-1:0]         cell_hit;
  logic [DEPTH-1:0]         match;

  logic           root_hit;
  logic [L-1:0]   root_idx;

  logic           accept;
  op_e            op;
  status_e        st;
  logic [PW-1:0]  pos_ext;
  logic [PW-1:0]  cnt_ext;
  logic [PW-1:0]  tgt;

  assign accept  = start && !busy;
  assign busy    = (state == S_SCAN);
  assign op      = op_e'(operation);
  assign pos_ext = PW'(position);
  assign cnt_ext = PW'(count);

  // decode one beat: status, target slot and the command broadcast to the cells
  always_comb begin
    st         = ST_OK;
    tgt        = '0;
    count_next = count;
    cmd.kind   = CMD_NONE;
    cmd.value  = value;
    unique case (op)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        if (op == OP_INS_FRONT) begin
          tgt = '0;
        end else if (op == OP_INS_BACK) begin
          tgt = cnt_ext;
        end else begin
          tgt = pos_ext;
        end
        if (count == CW'(DEPTH)) begin
          st = ST_FULL;
        end else if (tgt > cnt_ext) begin
          st = ST_BADPOS;
        end else begin
          cmd.kind   = CMD_INS;
          count_next = count + CW'(1);
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
        if (op == OP_DEL_FRONT) begin
          tgt = '0;
        end else if (op == OP_DEL_BACK) begin
          tgt = cnt_ext - PW'(1);
        end else begin
          tgt = pos_ext;
        end
        if (count == '0) begin
          st = ST_EMPTY;
        end else if (tgt >= cnt_ext) begin
          st = ST_BADPOS;
        end else begin
          cmd.kind   = CMD_DEL;
          count_next = count - CW'(1);
        end
      end
      OP_UPDATE: begin
        tgt = pos_ext;
        if (tgt >= cnt_ext) begin
          st = ST_BADPOS;
        end else begin
          cmd.kind = CMD_UPD;
        end
      end
      OP_SEARCH: begin
        st = ST_NOTFOUND;
      end
      default: begin
      end
    endcase
    cmd.pos = IDX_W'(tgt);
    if (!accept) begin
      cmd.kind   = CMD_NONE;
      count_next = count;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [DATA_W-1:0] lft, rgt;
      if (gi == 0) begin : g_first
        assign lft = '0;
      end else begin : g_mid_l
        assign lft = ent[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign rgt = '0;
      end else begin : g_mid_r
        assign rgt = ent[gi+1];
      end

      ota_cell #(
        .INDEX (gi)
      ) u_cell (
        .clk   (clk),
        .cmd   (cmd),
        .left  (lft),
        .right (rgt),
        .entry (ent[gi]),
        .hit   (cell_hit[gi])
      );

      // only occupied slots may match
      assign match[gi] = cell_hit[gi] && (CW'(gi) < count);
    end
  endgenerate

  // first-match tree, loaded on a search beat
  ota_first #(
    .DEPTH (DEPTH)
  ) u_first (
    .clk      (clk),
    .load     (accept && (op == OP_SEARCH)),
    .match    (match),
    .root_hit (root_hit),
    .root_idx (root_idx)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (op == OP_SEARCH)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (step == SW'(L)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= 1'b0;
      if (state == S_IDLE) begin
        step <= '0;
        // immediate result for everything but a search
        if (accept && (op != OP_SEARCH)) begin
          done <= 1'b1;
        end
      end else begin
        step <= step + SW'(1);
        // tree has reduced to its root
        if (step == SW'(L)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && accept && (op != OP_SEARCH)) begin
      status      <= st;
      found_index <= '0;
      fill_count  <= 9'(count_next);
    end else if ((state == S_SCAN) && (step == SW'(L))) begin
      if (root_hit) begin
        status      <= ST_OK;
        found_index <= 8'(root_idx);
      end else begin
        status      <= ST_NOTFOUND;
        found_index <= '0;
      end
      fill_count <= 9'(count);
    end
  end

  // a plain operation answers on the very next cycle
  a_plain_done : assert property (@(posedge clk) disable iff (rst)
    (accept && (op != OP_SEARCH)) |=> done)
    else $error("plain operation gave no result beat");

  // a search holds the block busy and gives no immediate beat
  a_search_busy : assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_SEARCH)) |=> (busy && !done))
    else $error("search did not enter scan");

  // a full report comes only from a full table
  a_full_count : assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL)) |-> (fill_count == 9'(DEPTH)))
    else $error("full status with table not full");

  // fill count never runs past the depth
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    (count <= CW'(DEPTH)))
    else $error("fill count beyond depth");

endmodule
`default_nettype wire

@@ rtl/core/ota_cell.sv @@
`default_nettype none
module ota_cell #(
  parameter int INDEX = 0
) (
  input  logic                             clk,
  input  ota_pkg::cmd_t                    cmd,
  input  logic signed [ota_pkg::DATA_W-1:0] left,
  input  logic signed [ota_pkg::DATA_W-1:0] right,
  output logic signed [ota_pkg::DATA_W-1:0] entry,
  output logic                             hit
);
  import ota_pkg::*;

  localparam logic [IDX_W-1:0] IDX = IDX_W'(INDEX);

  always_ff @(posedge clk) begin
    unique case (cmd.kind)
      CMD_INS: begin
        if (IDX > cmd.pos) begin
          entry <= left;
        end else if (IDX == cmd.pos) begin
          entry <= cmd.value;
        end
      end
      CMD_DEL: begin
        if (IDX >= cmd.pos) begin
          entry <= right;
        end
      end
      CMD_UPD: begin
        if (IDX == cmd.pos) begin
          entry <= cmd.value;
        end
      end
      CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

  assign hit = (entry == cmd.value);

endmodule
`default_nettype wire

@@ rtl/core/ota_first.sv @@
`default_nettype none
module ota_first #(
  parameter int DEPTH = ota_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic [DEPTH-1:0]           match,
  output logic                       root_hit,
  output logic [$clog2(DEPTH)-1:0]   root_idx
);
  import ota_pkg::*;

  localparam int L  = $clog2(DEPTH);
  localparam int NP = 1 << L;

  logic [NP-1:0] match_pad;
  logic          node_hit [NP];
  logic [L-1:0]  node_idx [NP];

  assign match_pad = NP'(match);

  // halve the tree in place each cycle, lower index wins
  always_ff @(posedge clk) begin
    if (load) begin
      for (int j = 0; j < NP; j++) begin
        node_hit[j] <= match_pad[j];
        node_idx[j] <= L'(j);
      end
    end else begin
      for (int j = 0; j < NP; j++) begin
        if (j < NP / 2) begin
          node_hit[j] <= node_hit[2*j] | node_hit[2*j+1];
          node_idx[j] <= node_hit[2*j] ? node_idx[2*j] : node_idx[2*j+1];
        end else begin
          node_hit[j] <= 1'b0;
        end
      end
    end
  end

  assign root_hit = node_hit[0];
  assign root_idx = node_idx[0];

endmodule
`default_nettype wire

@@ dv/ordered_array_table_engine_tb.sv @@
`default_nettype none
module ordered_array_table_engine_tb;
  import ota_pkg::*;

  localparam int TBL_DEPTH = 256;
  // quiet cycles allowed before the run is declared hung; searches are short
  // and sender gaps are short, so this is generous
  localparam int WATCHDOG_LIMIT = 4000;
  // settle time after the last result
  localparam int SETTLE_CYCLES = 24;

  // how the random operation mix leans
  typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} op_mix_e;

  // one expected result beat
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] found_index;
    logic [8:0] fill_count;
  } table_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [2:0]               operation = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic [7:0]               position = '0;
  logic                     busy;
  logic                     done;
  logic [2:0]               status;
  logic [7:0]               found_index;
  logic [8:0]               fill_count;

  // shadow copy of the table, updated when a command beat is accepted
  logic signed [DATA_W-1:0] shadow_entries [TBL_DEPTH];
  int                       shadow_count = 0;

  table_result_t pending_results [$];
  table_result_t oldest;

  int sender_idle_pct = 0;
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int full_seen = 0;
  int empty_seen = 0;
  int search_hits = 0;
  int quiet_cycles = 0;

  ordered_array_table_engine #(
    .DEPTH(TBL_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .value(value),
    .position(position),
    .done(done),
    .status(status),
    .found_index(found_index),
    .fill_count(fill_count)
  );

  always #10 clk = ~clk;

  // work out the result of one operation and apply it to the shadow table
  function automatic table_result_t apply_table_op(op_e op, logic signed [DATA_W-1:0] v,
                                                   logic [7:0] pos);
    table_result_t r;
    int at;
    int i;
    r.status = ST_OK;
    r.found_index = '0;
    case (op)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        if (op == OP_INS_FRONT) at = 0;
        else if (op == OP_INS_BACK) at = shadow_count;
        else at = int'(pos);
        if (shadow_count >= TBL_DEPTH) begin
          r.status = ST_FULL;
        end else if (at > shadow_count) begin
          r.status = ST_BADPOS;
        end else begin
          // open a gap at the insert point
          for (i = shadow_count; i > at; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[at] = v;
          shadow_count++;
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
        if (op == OP_DEL_FRONT) at = 0;
        else if (op == OP_DEL_BACK) at = shadow_count - 1;
        else at = int'(pos);
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (at >= shadow_count) begin
          r.status = ST_BADPOS;
        end else begin
          // close the gap left by the removed entry
          for (i = at; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      OP_UPDATE: begin
        if (int'(pos) >= shadow_count) r.status = ST_BADPOS;
        else shadow_entries[pos] = v;
      end
      default: begin
        // first match wins, only written entries are looked at
        r.status = ST_NOTFOUND;
        for (i = 0; i < shadow_count && r.status != ST_OK; i++) begin
          if (shadow_entries[i] == v) begin
            r.status = ST_OK;
            r.found_index = i[7:0];
          end
        end
      end
    endcase
    r.fill_count = shadow_count[8:0];
    return r;
  endfunction

  // values lean towards what the table already holds so that searches hit
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 3 && shadow_count > 0) return shadow_entries[$urandom_range(shadow_count - 1)];
    if (sel < 6) begin
      case ($urandom_range(5))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return 32'sd0;
        3: return -32'sd1;
        4: return 32'sd1;
        default: return $signed(32'($urandom_range(15))) - 32'sd8;
      endcase
    end
    return $urandom;
  endfunction

  // positions mostly near the valid range, some anywhere in the field
  function automatic logic [7:0] pick_position();
    int lim;
    int unsigned sel;
    lim = (shadow_count > 255) ? 255 : shadow_count;
    sel = $urandom_range(9);
    if (sel < 5) return 8'($urandom_range(lim));
    if (sel == 5) return 8'(lim);
    if (sel == 6) return 8'((lim > 0) ? lim - 1 : 0);
    return 8'($urandom_range(255));
  endfunction

  function automatic op_e pick_op(op_mix_e mix);
    int unsigned sel;
    sel = $urandom_range(99);
    case (mix)
      MIX_GROW: begin
        if (sel < 75) return op_e'($urandom_range(2));
        if (sel < 88) return op_e'(3 + $urandom_range(2));
        return op_e'(6 + $urandom_range(1));
      end
      MIX_SHRINK: begin
        if (sel < 75) return op_e'(3 + $urandom_range(2));
        if (sel < 88) return op_e'($urandom_range(2));
        return op_e'(6 + $urandom_range(1));
      end
      default: return op_e'($urandom_range(7));
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // send one command beat; the sender may idle first, and start is left high after
  // acceptance until a later idle or pause of the sender lowers it
  task automatic send_op(op_e op, logic signed [DATA_W-1:0] v, logic [7:0] pos);
    table_result_t exp_r;
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    operation <= op;
    value <= v;
    position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    exp_r = apply_table_op(op, v, pos);
    pending_results.push_back(exp_r);
    items_sent++;
    if (exp_r.status == ST_FULL) full_seen++;
    if (exp_r.status == ST_EMPTY) empty_seen++;
    if (op == OP_SEARCH && exp_r.status == ST_OK) search_hits++;
  endtask

  task automatic send_random(op_mix_e mix);
    op_e op;
    op = pick_op(mix);
    send_op(op, pick_value(), pick_position());
  endtask

  // stop offering beats and hold off until every result is back
  task automatic pause_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // edges on an empty and a small table: empty, bad position, not found,
  // append at the count, duplicates and the extreme values
  task automatic test_directed_edges();
    sender_idle_pct = 0;
    send_op(OP_DEL_FRONT, $urandom, 8'($urandom));
    send_op(OP_DEL_BACK, $urandom, 8'($urandom));
    send_op(OP_DEL_AT, $urandom, 8'd0);
    send_op(OP_UPDATE, 32'sd5, 8'd0);
    send_op(OP_SEARCH, 32'sd0, 8'($urandom));
    send_op(OP_INS_AT, 32'sd9, 8'd1);
    send_op(OP_INS_FRONT, 32'sh7fffffff, 8'($urandom));
    send_op(OP_INS_BACK, 32'sh80000000, 8'($urandom));
    send_op(OP_INS_AT, 32'sd0, 8'd1);
    send_op(OP_INS_AT, -32'sd1, 8'd3);
    send_op(OP_INS_AT, 32'sd7, 8'd255);
    send_op(OP_SEARCH, -32'sd1, 8'($urandom));
    send_op(OP_INS_FRONT, -32'sd1, 8'($urandom));
    send_op(OP_SEARCH, -32'sd1, 8'($urandom));
    send_op(OP_UPDATE, 32'sh55555555, 8'd2);
    send_op(OP_UPDATE, 32'sd3, 8'd5);
    send_op(OP_UPDATE, 32'sd3, 8'd255);
    send_op(OP_SEARCH, 32'shAAAAAAAA, 8'($urandom));
    send_op(OP_DEL_AT, $urandom, 8'd5);
    send_op(OP_DEL_AT, $urandom, 8'd255);
    send_op(OP_DEL_AT, $urandom, 8'd1);
    send_op(OP_DEL_FRONT, $urandom, 8'($urandom));
    send_op(OP_DEL_BACK, $urandom, 8'($urandom));
    send_op(OP_SEARCH, 32'sh80000000, 8'($urandom));
  endtask

  // grow the table to full with a light sender gap, then keep hitting it
  task automatic test_fill_to_full();
    sender_idle_pct = 19;
    while (shadow_count < TBL_DEPTH) send_random(MIX_GROW);
    repeat (40) send_random(MIX_GROW);
  endtask

  // balanced churn with a heavy sender gap, draining the results now and then
  task automatic test_mixed_churn();
    sender_idle_pct = 73;
    for (int n = 0; n < 100; n++) begin
      send_random(MIX_EVEN);
      if (n % 50 == 49) pause_until_drained();
    end
  endtask

  // back to back beats: empty the table, poke at it empty, then churn again
  task automatic test_drain_to_empty();
    sender_idle_pct = 0;
    while (shadow_count > 0) send_random(MIX_SHRINK);
    repeat (30) send_random(MIX_SHRINK);
    repeat (100) send_random(MIX_EVEN);
  endtask

  // result checker: every done beat is matched against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        oldest = pending_results.pop_front();
        if (status !== oldest.status)
          report_mismatch($sformatf("status exp %0d got %0d", oldest.status, status));
        if (found_index !== oldest.found_index)
          report_mismatch($sformatf("found_index exp %0d got %0d",
                                    oldest.found_index, found_index));
        if (fill_count !== oldest.fill_count)
          report_mismatch($sformatf("fill_count exp %0d got %0d",
                                    oldest.fill_count, fill_count));
        results_checked++;
      end
    end
  end

  // watchdog: any accepted beat on either side counts as progress
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ordered_array_table_engine test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_fill_to_full();
    test_mixed_churn();
    test_drain_to_empty();

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d operations, %0d result beats checked", items_sent, results_checked);
    $display("full refusals %0d, empty refusals %0d, search hits %0d",
             full_seen, empty_seen, search_hits);
    if (error_count == 0) begin
      $display("ordered_array_table_engine test passed");
    end else begin
      $display("ordered_array_table_engine test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
